// ----- rtl/tnt_pkg.sv -----
// ----------------------------------------------------------------------------
// tnt_pkg
// Shared types and constants of the triangle normal and tangent unit.
// ----------------------------------------------------------------------------
package tnt_pkg;

   localparam int COORD_BITS_DEF = 20;
   localparam int TEX_BITS       = 24;
   localparam int TAN_W          = 16;
   localparam int MAG_W          = 30;
   localparam int ROOT_W         = 62;
   localparam int ROOT_TOP       = 60;
   localparam int ROOT_STEPS     = 31;
   localparam int LEN_W          = 31;
   localparam int DIV_STEPS      = 16;
   localparam int DIV_N_W        = 46;
   localparam int Q15_FRAC       = 15;
   localparam logic [TAN_W-2:0] Q15_MAX = 15'h7fff;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EDGE,
      ST_MUL,
      ST_CHECK,
      ST_NORM,
      ST_SQ,
      ST_RINIT,
      ST_ROOT,
      ST_DLOAD,
      ST_DSTEP,
      ST_DSTORE,
      ST_FIN
   } state_type;

   typedef enum logic [2:0] {
      PR_NX,
      PR_NY,
      PR_NZ,
      PR_DEN,
      PR_NUM0,
      PR_NUM1,
      PR_NUM2
   } pair_type;

   typedef struct packed {
      logic       load_first;
      logic       load_second;
      logic       load_last;
      logic       clear_all;
      logic       edge_calc;
      logic       mul_issue;
      logic       mul_write;
      pair_type   sel;
      pair_type   wsel;
      logic       clear_tan;
      logic       mag_load;
      logic       norm_step;
      logic       sq_issue;
      logic       sq_clr;
      logic       sq_acc;
      logic [1:0] comp;
      logic       root_init;
      logic       root_step;
      logic       div_load;
      logic       div_step;
      logic       div_store;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic den_zero;
      logic num_zero;
      logic norm_done;
   } status_type;

endpackage

// ----- rtl/tnt_ctrl.sv -----
// ----------------------------------------------------------------------------
// tnt_ctrl
// Sequencer: corner bookkeeping, step order of the datapath, result handshake.
// ----------------------------------------------------------------------------
module tnt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_last_corner,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output tnt_pkg::cmd_type     cmd,
   input  tnt_pkg::status_type  status
);

   tnt_pkg::state_type state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [1:0] comp_ff, comp_in;
   logic [1:0] count_ff, count_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tnt_pkg::ST_IDLE;
         cnt_ff       <= '0;
         comp_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         comp_ff      <= comp_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      comp_in      = comp_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      cmd          = '0;
      cmd.comp     = comp_ff;
      req_stall    = (state_ff != tnt_pkg::ST_IDLE);
      case (state_ff)
         tnt_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (!req_last_corner) begin
                  case (count_ff)
                     2'd0: begin
                        cmd.load_first = 1'b1;
                        count_in       = 2'd1;
                     end
                     2'd1: begin
                        cmd.load_second = 1'b1;
                        count_in        = 2'd2;
                     end
                     default: ;
                  endcase
               end else begin
                  count_in = 2'd0;
                  if (count_ff == 2'd2) begin
                     cmd.load_last = 1'b1;
                     state_in      = tnt_pkg::ST_EDGE;
                  end else begin
                     cmd.clear_all = 1'b1;
                     state_in      = tnt_pkg::ST_FIN;
                  end
               end
            end
         end
         tnt_pkg::ST_EDGE: begin
            cmd.edge_calc = 1'b1;
            cnt_in        = '0;
            state_in      = tnt_pkg::ST_MUL;
         end
         tnt_pkg::ST_MUL: begin
            cmd.sel  = tnt_pkg::pair_type'(cnt_ff[2:0]);
            cmd.wsel = tnt_pkg::pair_type'(cnt_ff[2:0] - 3'd1);
            cmd.mul_issue = (cnt_ff < 5'd7);
            cmd.mul_write = (cnt_ff != 5'd0);
            if (cnt_ff == 5'd7) begin
               state_in = tnt_pkg::ST_CHECK;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         tnt_pkg::ST_CHECK: begin
            if (status.den_zero || status.num_zero) begin
               cmd.clear_tan = 1'b1;
               state_in      = tnt_pkg::ST_FIN;
            end else begin
               cmd.mag_load = 1'b1;
               state_in     = tnt_pkg::ST_NORM;
            end
         end
         tnt_pkg::ST_NORM: begin
            if (status.norm_done) begin
               cnt_in   = '0;
               state_in = tnt_pkg::ST_SQ;
            end else begin
               cmd.norm_step = 1'b1;
            end
         end
         tnt_pkg::ST_SQ: begin
            cmd.comp     = cnt_ff[1:0];
            cmd.sq_issue = (cnt_ff < 5'd3);
            cmd.sq_clr   = (cnt_ff == 5'd0);
            cmd.sq_acc   = (cnt_ff != 5'd0);
            if (cnt_ff == 5'd3) begin
               state_in = tnt_pkg::ST_RINIT;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         tnt_pkg::ST_RINIT: begin
            cmd.root_init = 1'b1;
            cnt_in        = '0;
            state_in      = tnt_pkg::ST_ROOT;
         end
         tnt_pkg::ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (cnt_ff == 5'(tnt_pkg::ROOT_STEPS - 1)) begin
               comp_in  = '0;
               state_in = tnt_pkg::ST_DLOAD;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         tnt_pkg::ST_DLOAD: begin
            cmd.div_load = 1'b1;
            cnt_in       = '0;
            state_in     = tnt_pkg::ST_DSTEP;
         end
         tnt_pkg::ST_DSTEP: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == 5'(tnt_pkg::DIV_STEPS - 1)) begin
               state_in = tnt_pkg::ST_DSTORE;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         tnt_pkg::ST_DSTORE: begin
            cmd.div_store = 1'b1;
            if (comp_ff == 2'd2) begin
               state_in = tnt_pkg::ST_FIN;
            end else begin
               comp_in  = comp_ff + 2'd1;
               state_in = tnt_pkg::ST_DLOAD;
            end
         end
         tnt_pkg::ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = tnt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tnt_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while a beat waits");

   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("loaded result not offered");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("corner count out of range");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_last_corner) |=> (count_ff == 2'd0))
      else $error("corner count not cleared after last corner");

   a_comp_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tnt_pkg::ST_DSTEP) |-> (comp_ff != 2'd3))
      else $error("component index out of range");

endmodule

// ----- rtl/tnt_dp.sv -----
// ----------------------------------------------------------------------------
// tnt_dp
// Datapath: corner store, shared multiplier pair, normaliser, square root,
// divider and result register.
// ----------------------------------------------------------------------------
module tnt_dp #(
   parameter int CoordBits = tnt_pkg::COORD_BITS_DEF
) (
   input  logic                                 clock,
   input  tnt_pkg::cmd_type                     cmd,
   output tnt_pkg::status_type                  status,
   input  logic signed [CoordBits-1:0]          req_pos_x,
   input  logic signed [CoordBits-1:0]          req_pos_y,
   input  logic signed [CoordBits-1:0]          req_pos_z,
   input  logic signed [tnt_pkg::TEX_BITS-1:0]  req_tex_u,
   input  logic signed [tnt_pkg::TEX_BITS-1:0]  req_tex_v,
   output logic signed [2*CoordBits+1:0]        rsp_normal_x,
   output logic signed [2*CoordBits+1:0]        rsp_normal_y,
   output logic signed [2*CoordBits+1:0]        rsp_normal_z,
   output logic signed [tnt_pkg::TAN_W-1:0]     rsp_tangent_x,
   output logic signed [tnt_pkg::TAN_W-1:0]     rsp_tangent_y,
   output logic signed [tnt_pkg::TAN_W-1:0]     rsp_tangent_z,
   output logic                                 rsp_degenerate
);

   localparam int CB  = CoordBits;
   localparam int XB  = tnt_pkg::TEX_BITS;
   localparam int EW  = CB + 1;
   localparam int TW  = XB + 1;
   localparam int OPW = (EW > TW) ? EW : TW;
   localparam int PW  = 2 * OPW;
   localparam int DW  = PW + 1;
   localparam int NW  = 2 * CB + 2;
   localparam int MW  = DW;
   localparam int GW  = tnt_pkg::MAG_W;
   localparam int RW  = tnt_pkg::ROOT_W;
   localparam int LW  = tnt_pkg::LEN_W;
   localparam int QW  = tnt_pkg::TAN_W;
   localparam int NDW = tnt_pkg::DIV_N_W;
   localparam int DS  = tnt_pkg::DIV_STEPS;

   logic signed [CB-1:0] in_pos [3];
   logic signed [XB-1:0] in_tex [2];

   logic signed [CB-1:0] f_pos_ff [3];
   logic signed [CB-1:0] s_pos_ff [3];
   logic signed [CB-1:0] l_pos_ff [3];
   logic signed [XB-1:0] f_tex_ff [2];
   logic signed [XB-1:0] s_tex_ff [2];
   logic signed [XB-1:0] l_tex_ff [2];

   logic signed [EW-1:0] e1_ff [3];
   logic signed [EW-1:0] e2_ff [3];
   logic signed [TW-1:0] u10_ff, u20_ff, v10_ff, v20_ff;

   logic signed [OPW-1:0] op_a, op_b, op_c, op_d;
   logic signed [PW-1:0]  mul_a_ff, mul_b_ff;
   logic signed [DW-1:0]  diff;

   logic signed [NW-1:0] nrm_ff [3];
   logic signed [DW-1:0] num_ff [3];
   logic                 den_zero_ff, den_neg_ff;

   logic [MW-1:0] m_ff [3];
   logic          neg_ff [3];
   logic          hi4, hi1, lo4, lo1;

   logic [GW-1:0]   sq_op;
   logic [2*GW-1:0] sq_prod_ff;
   logic [RW-1:0]   acc_ff;

   logic [RW-1:0] rs_ff, rr_ff, rb_ff, rt;
   logic [LW-1:0] len;

   logic [NDW-1:0] dn;
   logic [LW:0]    rem_ff, rem2;
   logic [DS-1:0]  low_ff;
   logic [QW-1:0]  q_ff;
   logic [QW-2:0]  qs;
   logic [QW-1:0]  tval;

   logic signed [QW-1:0] tan_ff [3];
   logic                 degen_ff;

   logic signed [NW-1:0] o_nrm_ff [3];
   logic signed [QW-1:0] o_tan_ff [3];
   logic                 o_degen_ff;

   assign in_pos[0] = req_pos_x;
   assign in_pos[1] = req_pos_y;
   assign in_pos[2] = req_pos_z;
   assign in_tex[0] = req_tex_u;
   assign in_tex[1] = req_tex_v;

   // corner store and edges
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (cmd.load_first)  f_pos_ff[i] <= in_pos[i];
         if (cmd.load_second) s_pos_ff[i] <= in_pos[i];
         if (cmd.load_last)   l_pos_ff[i] <= in_pos[i];
         if (cmd.edge_calc) begin
            e1_ff[i] <= EW'(s_pos_ff[i]) - EW'(f_pos_ff[i]);
            e2_ff[i] <= EW'(l_pos_ff[i]) - EW'(f_pos_ff[i]);
         end
      end
      for (int j = 0; j < 2; j++) begin
         if (cmd.load_first)  f_tex_ff[j] <= in_tex[j];
         if (cmd.load_second) s_tex_ff[j] <= in_tex[j];
         if (cmd.load_last)   l_tex_ff[j] <= in_tex[j];
      end
      if (cmd.edge_calc) begin
         u10_ff <= TW'(s_tex_ff[0]) - TW'(f_tex_ff[0]);
         u20_ff <= TW'(l_tex_ff[0]) - TW'(f_tex_ff[0]);
         v10_ff <= TW'(s_tex_ff[1]) - TW'(f_tex_ff[1]);
         v20_ff <= TW'(l_tex_ff[1]) - TW'(f_tex_ff[1]);
      end
   end

   // operand select for the multiplier pair
   always_comb begin
      op_a = '0;
      op_b = '0;
      op_c = '0;
      op_d = '0;
      case (cmd.sel)
         tnt_pkg::PR_NX: begin
            op_a = OPW'(e1_ff[1]); op_b = OPW'(e2_ff[2]);
            op_c = OPW'(e1_ff[2]); op_d = OPW'(e2_ff[1]);
         end
         tnt_pkg::PR_NY: begin
            op_a = OPW'(e1_ff[2]); op_b = OPW'(e2_ff[0]);
            op_c = OPW'(e1_ff[0]); op_d = OPW'(e2_ff[2]);
         end
         tnt_pkg::PR_NZ: begin
            op_a = OPW'(e1_ff[0]); op_b = OPW'(e2_ff[1]);
            op_c = OPW'(e1_ff[1]); op_d = OPW'(e2_ff[0]);
         end
         tnt_pkg::PR_DEN: begin
            op_a = OPW'(u10_ff); op_b = OPW'(v20_ff);
            op_c = OPW'(v10_ff); op_d = OPW'(u20_ff);
         end
         tnt_pkg::PR_NUM0: begin
            op_a = OPW'(v20_ff); op_b = OPW'(e1_ff[0]);
            op_c = OPW'(v10_ff); op_d = OPW'(e2_ff[0]);
         end
         tnt_pkg::PR_NUM1: begin
            op_a = OPW'(v20_ff); op_b = OPW'(e1_ff[1]);
            op_c = OPW'(v10_ff); op_d = OPW'(e2_ff[1]);
         end
         tnt_pkg::PR_NUM2: begin
            op_a = OPW'(v20_ff); op_b = OPW'(e1_ff[2]);
            op_c = OPW'(v10_ff); op_d = OPW'(e2_ff[2]);
         end
         default: ;
      endcase
   end

   assign diff = DW'(mul_a_ff) - DW'(mul_b_ff);

   always_ff @(posedge clock) begin
      if (cmd.mul_issue) begin
         mul_a_ff <= op_a * op_b;
         mul_b_ff <= op_c * op_d;
      end
      if (cmd.mul_write) begin
         case (cmd.wsel)
            tnt_pkg::PR_NX:   nrm_ff[0] <= diff[NW-1:0];
            tnt_pkg::PR_NY:   nrm_ff[1] <= diff[NW-1:0];
            tnt_pkg::PR_NZ:   nrm_ff[2] <= diff[NW-1:0];
            tnt_pkg::PR_DEN: begin
               den_zero_ff <= (diff == '0);
               den_neg_ff  <= diff[DW-1];
            end
            tnt_pkg::PR_NUM0: num_ff[0] <= diff;
            tnt_pkg::PR_NUM1: num_ff[1] <= diff;
            tnt_pkg::PR_NUM2: num_ff[2] <= diff;
            default: ;
         endcase
      end
      if (cmd.clear_all) begin
         for (int i = 0; i < 3; i++) nrm_ff[i] <= '0;
      end
   end

   // normaliser: largest magnitude brought into [2^29, 2^30)
   always_comb begin
      hi4 = 1'b0;
      hi1 = 1'b0;
      lo4 = 1'b1;
      lo1 = 1'b1;
      for (int i = 0; i < 3; i++) begin
         hi4 = hi4 | (|m_ff[i][MW-1:GW+4]);
         hi1 = hi1 | (|m_ff[i][MW-1:GW]);
         lo4 = lo4 & ~(|m_ff[i][MW-1:GW-5]);
         lo1 = lo1 & ~(|m_ff[i][MW-1:GW-1]);
      end
   end

   assign status.den_zero  = den_zero_ff;
   assign status.num_zero  = (num_ff[0] == '0) && (num_ff[1] == '0) && (num_ff[2] == '0);
   assign status.norm_done = !hi1 && !lo1;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (cmd.mag_load) begin
            m_ff[i]   <= num_ff[i][DW-1] ? MW'(-num_ff[i]) : MW'(num_ff[i]);
            neg_ff[i] <= num_ff[i][DW-1] ^ den_neg_ff;
         end else if (cmd.norm_step) begin
            if (hi4)      m_ff[i] <= m_ff[i] >> 4;
            else if (hi1) m_ff[i] <= m_ff[i] >> 1;
            else if (lo4) m_ff[i] <= m_ff[i] << 4;
            else          m_ff[i] <= m_ff[i] << 1;
         end
      end
   end

   // sum of squares
   assign sq_op = m_ff[cmd.comp][GW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.sq_issue) sq_prod_ff <= sq_op * sq_op;
      if (cmd.sq_clr)      acc_ff <= '0;
      else if (cmd.sq_acc) acc_ff <= acc_ff + RW'(sq_prod_ff);
   end

   // square root, one result bit per step
   assign rt  = rr_ff + rb_ff;
   assign len = rr_ff[LW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.root_init) begin
         rs_ff <= acc_ff;
         rr_ff <= '0;
         rb_ff <= RW'(1) << tnt_pkg::ROOT_TOP;
      end else if (cmd.root_step) begin
         if (rs_ff >= rt) begin
            rs_ff <= rs_ff - rt;
            rr_ff <= (rr_ff >> 1) + rb_ff;
         end else begin
            rr_ff <= rr_ff >> 1;
         end
         rb_ff <= rb_ff >> 2;
      end
   end

   // restoring divider, one quotient bit per step
   assign dn   = NDW'({sq_op, {tnt_pkg::Q15_FRAC{1'b0}}}) + NDW'(len[LW-1:1]);
   assign rem2 = {rem_ff[LW-1:0], low_ff[DS-1]};
   assign qs   = q_ff[QW-1] ? tnt_pkg::Q15_MAX : q_ff[QW-2:0];
   assign tval = {1'b0, qs};

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff <= (LW+1)'(dn[NDW-1:DS]);
         low_ff <= dn[DS-1:0];
         q_ff   <= '0;
      end else if (cmd.div_step) begin
         if (rem2 >= (LW+1)'(len)) begin
            rem_ff <= rem2 - (LW+1)'(len);
            q_ff   <= {q_ff[QW-2:0], 1'b1};
         end else begin
            rem_ff <= rem2;
            q_ff   <= {q_ff[QW-2:0], 1'b0};
         end
         low_ff <= low_ff << 1;
      end
   end

   // tangent, flag and result register
   always_ff @(posedge clock) begin
      if (cmd.clear_all || cmd.clear_tan) begin
         for (int i = 0; i < 3; i++) tan_ff[i] <= '0;
         degen_ff <= 1'b1;
      end else if (cmd.div_store) begin
         tan_ff[cmd.comp] <= neg_ff[cmd.comp] ? QW'(0) - tval : tval;
      end
      if (cmd.edge_calc) degen_ff <= 1'b0;
      if (cmd.out_load) begin
         for (int i = 0; i < 3; i++) begin
            o_nrm_ff[i] <= nrm_ff[i];
            o_tan_ff[i] <= tan_ff[i];
         end
         o_degen_ff <= degen_ff;
      end
   end

   assign rsp_normal_x   = o_nrm_ff[0];
   assign rsp_normal_y   = o_nrm_ff[1];
   assign rsp_normal_z   = o_nrm_ff[2];
   assign rsp_tangent_x  = o_tan_ff[0];
   assign rsp_tangent_y  = o_tan_ff[1];
   assign rsp_tangent_z  = o_tan_ff[2];
   assign rsp_degenerate = o_degen_ff;

endmodule

// ----- rtl/triangle_normal_tangent.sv -----
// ----------------------------------------------------------------------------
// triangle_normal_tangent
// Face normal and unit tangent per polygon from a stream of corners.
// ----------------------------------------------------------------------------
// Corners enter on the req_ channel, one beat per corner, the final corner of
// a polygon marked by req_last_corner. The first two corners are stored; the
// last one closes the triangle and yields one beat on the rsp_ channel with
// the raw cross product e1 x e2, the unit tangent in Q1.15 and a degenerate
// flag. Corners between the second and the last are dropped.
// A last corner with fewer than two stored corners yields a zero normal, a
// zero tangent and a set degenerate flag. One multiplier pair forms every
// product; a triangle with a zero texture denominator or a zero tangent
// stops there, a full one goes on through a normalising shifter of up to
// eight steps, a 31-step square root and a bit-serial divider run once per
// tangent component.
// The result sits in an output register, so the next polygon's corners are
// taken while a result waits on rsp_stall; a further finished triangle waits
// for that register to empty. Reset clears the corner count and drops any
// pending result.
// ----------------------------------------------------------------------------
module triangle_normal_tangent #(
   parameter int CoordBits = tnt_pkg::COORD_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [CoordBits-1:0]          req_pos_x,
   input  logic signed [CoordBits-1:0]          req_pos_y,
   input  logic signed [CoordBits-1:0]          req_pos_z,
   input  logic signed [tnt_pkg::TEX_BITS-1:0]  req_tex_u,
   input  logic signed [tnt_pkg::TEX_BITS-1:0]  req_tex_v,
   input  logic                                 req_last_corner,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [2*CoordBits+1:0]        rsp_normal_x,
   output logic signed [2*CoordBits+1:0]        rsp_normal_y,
   output logic signed [2*CoordBits+1:0]        rsp_normal_z,
   output logic signed [tnt_pkg::TAN_W-1:0]     rsp_tangent_x,
   output logic signed [tnt_pkg::TAN_W-1:0]     rsp_tangent_y,
   output logic signed [tnt_pkg::TAN_W-1:0]     rsp_tangent_z,
   output logic                                 rsp_degenerate
);

   tnt_pkg::cmd_type    cmd;
   tnt_pkg::status_type status;

   tnt_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_last_corner (req_last_corner),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .cmd             (cmd),
      .status          (status)
   );

   tnt_dp #(
      .CoordBits (CoordBits)
   ) u_dp (
      .clock          (clock),
      .cmd            (cmd),
      .status         (status),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_pos_z      (req_pos_z),
      .req_tex_u      (req_tex_u),
      .req_tex_v      (req_tex_v),
      .rsp_normal_x   (rsp_normal_x),
      .rsp_normal_y   (rsp_normal_y),
      .rsp_normal_z   (rsp_normal_z),
      .rsp_tangent_x  (rsp_tangent_x),
      .rsp_tangent_y  (rsp_tangent_y),
      .rsp_tangent_z  (rsp_tangent_z),
      .rsp_degenerate (rsp_degenerate)
   );

endmodule

// ----- tb/tb_triangle_normal_tangent.sv -----
// ----------------------------------------------------------------------------
// tb_triangle_normal_tangent
// Self-checking testbench of the triangle normal and tangent unit.
// ----------------------------------------------------------------------------
// Corner beats are sent with random gaps; each last corner is run through an
// in-bench predictor of the normal, the Q1.15 tangent and the degenerate flag.
// Result beats, taken under random stall, are compared field by field with
// the oldest prediction. Directed tests cover short polygons, extra corners,
// axis tangents, zero denominators, zero numerators and field extremes;
// random polygons follow.
// ----------------------------------------------------------------------------
module tb_triangle_normal_tangent;

   localparam int CB         = tnt_pkg::COORD_BITS_DEF;
   localparam int TAN_W      = tnt_pkg::TAN_W;
   localparam int TEX_BITS   = tnt_pkg::TEX_BITS;
   localparam int NW         = 2*CB+2;
   localparam int IDLE_LIMIT = 3000;
   localparam int ONE_TEX    = 1 << 16;

   typedef struct {
      logic signed [NW-1:0]    nx, ny, nz;
      logic signed [TAN_W-1:0] tx, ty, tz;
      logic                    deg;
   } face_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [CB-1:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic signed [TEX_BITS-1:0] req_tex_u = '0, req_tex_v = '0;
   logic req_last_corner = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [NW-1:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic signed [TAN_W-1:0] rsp_tangent_x, rsp_tangent_y, rsp_tangent_z;
   logic rsp_degenerate;

   face_result_type pending_faces[$];
   int  errors = 0;
   int  corners_sent = 0;
   int  idle_cycles = 0;
   bit  idle_on = 1'b1;

   // polygon memory of the predictor
   longint first_pos[3], second_pos[3], first_tex[2], second_tex[2];
   logic [1:0] corner_cnt = '0;

   triangle_normal_tangent dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic longint unsigned int_sqrt(longint unsigned s);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s = s - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // returns 0 when the vector is zero
   function automatic bit unit_tangent(input longint a[3], output longint t[3]);
      longint unsigned m[3], mx, s, len, q;
      int b;
      mx = 0;
      s = 0;
      b = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = a[i] < 0 ? -a[i] : a[i];
         if (m[i] > mx) mx = m[i];
         t[i] = 0;
      end
      if (mx == 0) return 0;
      while (b < 64 && (mx >> b) != 0) b++;
      for (int i = 0; i < 3; i++) begin
         if (b > 30) m[i] = m[i] >> (b - 30);
         else m[i] = m[i] << (30 - b);
         s += m[i] * m[i];
      end
      len = int_sqrt(s);
      for (int i = 0; i < 3; i++) begin
         q = ((m[i] << 15) + (len >> 1)) / len;
         if (q > 32767) q = 32767;
         t[i] = a[i] < 0 ? -longint'(q) : longint'(q);
      end
      return 1;
   endfunction

   task automatic predict_corner(input longint p[3], input longint tx[2], input bit last);
      longint e1[3], e2[3], nrm[3], num[3], tn[3];
      longint u10, u20, v10, v20, den;
      bit degen;
      face_result_type r;
      degen = 1'b1;
      for (int i = 0; i < 3; i++) begin
         nrm[i] = 0;
         tn[i] = 0;
      end
      if (!last) begin
         if (corner_cnt == 0) begin
            first_pos = p;
            first_tex = tx;
            corner_cnt = 1;
         end else if (corner_cnt == 1) begin
            second_pos = p;
            second_tex = tx;
            corner_cnt = 2;
         end
         return;
      end
      if (corner_cnt == 2) begin
         for (int i = 0; i < 3; i++) begin
            e1[i] = second_pos[i] - first_pos[i];
            e2[i] = p[i] - first_pos[i];
         end
         nrm[0] = e1[1]*e2[2] - e1[2]*e2[1];
         nrm[1] = e1[2]*e2[0] - e1[0]*e2[2];
         nrm[2] = e1[0]*e2[1] - e1[1]*e2[0];
         u10 = second_tex[0] - first_tex[0];
         u20 = tx[0] - first_tex[0];
         v10 = second_tex[1] - first_tex[1];
         v20 = tx[1] - first_tex[1];
         den = u10*v20 - v10*u20;
         if (den != 0) begin
            for (int i = 0; i < 3; i++) begin
               num[i] = v20*e1[i] - v10*e2[i];
               if (den < 0) num[i] = -num[i];
            end
            degen = !unit_tangent(num, tn);
         end
      end
      corner_cnt = 0;
      r.nx = nrm[0][NW-1:0];
      r.ny = nrm[1][NW-1:0];
      r.nz = nrm[2][NW-1:0];
      r.tx = tn[0][TAN_W-1:0];
      r.ty = tn[1][TAN_W-1:0];
      r.tz = tn[2][TAN_W-1:0];
      r.deg = degen;
      pending_faces.push_back(r);
   endtask

   // one corner beat; called just after a rising edge
   task automatic send_corner(input longint x, y, z, u, v, input bit last);
      int gap;
      longint p[3], tx[2];
      gap = idle_on ? $urandom_range(0, 18) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pos_x <= x[CB-1:0];
      req_pos_y <= y[CB-1:0];
      req_pos_z <= z[CB-1:0];
      req_tex_u <= u[TEX_BITS-1:0];
      req_tex_v <= v[TEX_BITS-1:0];
      req_last_corner <= last;
      do @(posedge clock); while (req_stall);
      p[0] = longint'(req_pos_x);
      p[1] = longint'(req_pos_y);
      p[2] = longint'(req_pos_z);
      tx[0] = longint'(req_tex_u);
      tx[1] = longint'(req_tex_v);
      predict_corner(p, tx, last);
      corners_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_faces.size() != 0) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      errors++;
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
   endtask

   task automatic check_field(input string what, input longint got, input longint want);
      if (got != want) report_mismatch(what, got, want);
   endtask

   // result side: random stall per beat, compare with oldest prediction
   initial begin
      int hold;
      face_result_type w;
      @(negedge reset);
      forever begin
         hold = idle_on ? $urandom_range(0, 18) : 0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         if (pending_faces.size() == 0) begin
            report_mismatch("unexpected beat", 0, 0);
         end else begin
            w = pending_faces.pop_front();
            check_field("normal_x", rsp_normal_x, w.nx);
            check_field("normal_y", rsp_normal_y, w.ny);
            check_field("normal_z", rsp_normal_z, w.nz);
            check_field("tangent_x", rsp_tangent_x, w.tx);
            check_field("tangent_y", rsp_tangent_y, w.ty);
            check_field("tangent_z", rsp_tangent_z, w.tz);
            check_field("degenerate", rsp_degenerate, w.deg);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   task automatic test_short_polygons();
      send_corner(5, -3, 7, 100, 200, 1'b1);
      send_corner(1, 2, 3, 10, 20, 1'b0);
      send_corner(4, 5, 6, 30, 40, 1'b1);
   endtask

   task automatic test_axis_tangent();
      send_corner(0, 0, 0, 0, 0, 1'b0);
      send_corner(1, 0, 0, ONE_TEX, 0, 1'b0);
      send_corner(0, 1, 0, 0, ONE_TEX, 1'b1);
      // negative denominator
      send_corner(0, 0, 0, 0, 0, 1'b0);
      send_corner(1, 0, 0, 0, ONE_TEX, 1'b0);
      send_corner(0, 1, 0, ONE_TEX, 0, 1'b1);
   endtask

   task automatic test_degenerate_tex();
      // zero denominator, normal still present
      send_corner(0, 0, 0, 7, 7, 1'b0);
      send_corner(3, 1, 0, 7, 7, 1'b0);
      send_corner(0, 2, 5, 7, 7, 1'b1);
      // non-zero denominator, zero-length numerator
      send_corner(0, 0, 0, 0, 0, 1'b0);
      send_corner(1, 0, 0, 1, 1, 1'b0);
      send_corner(2, 0, 0, 0, 2, 1'b1);
   endtask

   task automatic test_extremes();
      longint cmax, cmin, tmax, tmin;
      cmax = (1 << (CB-1)) - 1;
      cmin = -(1 << (CB-1));
      tmax = (1 << (TEX_BITS-1)) - 1;
      tmin = -(1 << (TEX_BITS-1));
      send_corner(cmin, cmin, cmin, tmin, tmin, 1'b0);
      send_corner(cmax, cmin, cmax, tmax, tmin, 1'b0);
      send_corner(cmin, cmax, cmax, tmin, tmax, 1'b1);
      send_corner(cmax, cmax, cmax, tmax, tmax, 1'b0);
      send_corner(cmin, cmax, cmin, tmin, tmax, 1'b0);
      send_corner(cmax, cmin, cmin, tmax, tmin, 1'b1);
   endtask

   task automatic test_extra_corners();
      send_corner(1, 1, 1, 0, 0, 1'b0);
      send_corner(9, 2, -4, 3 * ONE_TEX, 5, 1'b0);
      send_corner(100, 100, 100, 12345, 999, 1'b0);
      send_corner(-50, 7, 8, -ONE_TEX, 77, 1'b0);
      send_corner(-3, 6, 11, 400, 2 * ONE_TEX, 1'b1);
   endtask

   function automatic longint rand_value(input int bits, input int mode);
      longint v;
      case (mode)
         0: v = $urandom_range(0, 16) - 8;
         1: v = $urandom_range(0, 2) ? -(1 << (bits-1)) : (1 << (bits-1)) - 1;
         default: v = {$urandom, $urandom};
      endcase
      v = v & ((64'd1 << bits) - 1);
      if (v[bits-1]) v = v - (64'sd1 << bits);
      return v;
   endfunction

   task automatic test_random_polygons();
      int n, mode;
      while (corners_sent < 375) begin
         if ($urandom_range(0, 7) == 0) idle_on = !idle_on;
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 5);
         mode = $urandom_range(0, 9);
         mode = mode < 3 ? 0 : (mode == 3 ? 1 : 2);
         for (int k = 0; k < n; k++)
            send_corner(rand_value(CB, mode), rand_value(CB, mode), rand_value(CB, mode),
                        rand_value(TEX_BITS, mode), rand_value(TEX_BITS, mode),
                        k == n - 1);
         if ($urandom_range(0, 40) == 0) wait_drained();
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_short_polygons();
      test_axis_tangent();
      test_degenerate_tex();
      wait_drained();
      test_extremes();
      test_extra_corners();
      test_random_polygons();
      wait_drained();
      repeat (150) @(posedge clock);
      if (errors == 0 && pending_faces.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
